// ===== rtl/at_sms_pkg.sv =====
package at_sms_pkg;

    localparam int MAX_LINE = 128;
    localparam int LINE_LEN_W = 8;

    localparam int TIMEOUT_W = 16;
    localparam int RETRY_W = 3;
    localparam int ELAPSED_W = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 3'd3;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // input opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_TRIGGER = 2'd2;

    localparam logic [7:0] BYTE_CR = 8'd13;
    localparam logic [7:0] BYTE_LF = 8'd10;

    localparam logic [15:0] PAT_OK = 16'h4F4B;
    localparam logic [15:0] PAT_PROMPT = 16'h3E20;
    localparam logic [47:0] PAT_CMGS = 48'h2B434D47533A;

    // pattern_seen bits
    localparam int SEEN_OK = 0;
    localparam int SEEN_PROMPT = 1;
    localparam int SEEN_CMGS = 2;

    // command codes
    localparam logic [2:0] CMD_AT = 3'd0;
    localparam logic [2:0] CMD_ATE0 = 3'd1;
    localparam logic [2:0] CMD_CSMS = 3'd2;
    localparam logic [2:0] CMD_CMGF = 3'd3;
    localparam logic [2:0] CMD_CSMP = 3'd4;
    localparam logic [2:0] CMD_CMGS = 3'd5;
    localparam logic [2:0] CMD_CONTENT = 3'd6;
    localparam logic [2:0] CMD_CTRL_Z = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE            = 4'd0,
        ST_INIT            = 4'd1,
        ST_HANDSHAKE       = 4'd2,
        ST_ECHO_OFF        = 4'd3,
        ST_CSMS_SET        = 4'd4,
        ST_TEXT_MODE       = 4'd5,
        ST_ENCODING_SET    = 4'd6,
        ST_PHONE_NUMBER    = 4'd7,
        ST_CONTENT_PROMPT  = 4'd8,
        ST_SEND_CONTENT    = 4'd9,
        ST_SEND_TERMINATOR = 4'd10,
        ST_CONFIRMATION    = 4'd11,
        ST_COMPLETE        = 4'd12,
        ST_ERROR           = 4'd13
    } t_seq_state;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_TICK    = 2'd1,
        EV_LINE    = 2'd2,
        EV_TRIGGER = 2'd3
    } t_ev_kind;

    typedef struct packed {
        t_ev_kind   kind;
        logic [2:0] seen;
    } t_event;

endpackage

// ===== rtl/at_sms_front.sv =====
module at_sms_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_q_full,
    output logic                o_push,
    output at_sms_pkg::t_event  o_event
);

    logic [at_sms_pkg::LINE_LEN_W-1:0] r_line_len, n_line_len;
    logic [47:0]                       r_recent, n_recent;
    logic [2:0]                        r_seen, n_seen;
    logic                              w_accept;

    assign o_in_ready = !i_q_full;
    assign w_accept = i_in_valid && !i_q_full;
    assign o_push = w_accept;

    always_comb begin
        n_line_len = r_line_len;
        n_recent = r_recent;
        n_seen = r_seen;
        o_event.kind = at_sms_pkg::EV_NONE;
        o_event.seen = r_seen;
        case (i_op)
            at_sms_pkg::OP_TICK: begin
                o_event.kind = at_sms_pkg::EV_TICK;
            end
            at_sms_pkg::OP_TRIGGER: begin
                o_event.kind = at_sms_pkg::EV_TRIGGER;
            end
            at_sms_pkg::OP_BYTE: begin
                if (i_rx_byte == at_sms_pkg::BYTE_CR || i_rx_byte == at_sms_pkg::BYTE_LF) begin
                    // line end carries what the line matched, then the line restarts
                    o_event.kind = at_sms_pkg::EV_LINE;
                    n_line_len = '0;
                    n_recent = '0;
                    n_seen = '0;
                end else if (r_line_len < at_sms_pkg::LINE_LEN_W'(at_sms_pkg::MAX_LINE - 1)) begin
                    n_line_len = r_line_len + 1'b1;
                    n_recent = {r_recent[39:0], i_rx_byte};
                    if (n_recent[15:0] == at_sms_pkg::PAT_OK) begin
                        n_seen[at_sms_pkg::SEEN_OK] = 1'b1;
                    end
                    if (n_recent[15:0] == at_sms_pkg::PAT_PROMPT) begin
                        n_seen[at_sms_pkg::SEEN_PROMPT] = 1'b1;
                    end
                    if (n_recent == at_sms_pkg::PAT_CMGS) begin
                        n_seen[at_sms_pkg::SEEN_CMGS] = 1'b1;
                    end
                end
            end
            default: begin
                o_event.kind = at_sms_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= '0;
            r_recent <= '0;
            r_seen <= '0;
        end else if (w_accept) begin
            r_line_len <= n_line_len;
            r_recent <= n_recent;
            r_seen <= n_seen;
        end
    end

endmodule

// ===== rtl/at_sms_fifo.sv =====
module at_sms_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  at_sms_pkg::t_event  i_data,
    input  logic                i_pop,
    output at_sms_pkg::t_event  o_data,
    output logic                o_empty,
    output logic                o_full
);

    at_sms_pkg::t_event                 r_mem [at_sms_pkg::Q_DEPTH];
    logic [at_sms_pkg::Q_PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [at_sms_pkg::Q_CNT_W-1:0]     r_count;
    logic                               w_push, w_pop;

    assign o_empty = (r_count == '0);
    assign o_full = (r_count == at_sms_pkg::Q_CNT_W'(at_sms_pkg::Q_DEPTH));
    assign w_push = i_push && !o_full;
    assign w_pop = i_pop && !o_empty;
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == at_sms_pkg::Q_PTR_W'(at_sms_pkg::Q_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == at_sms_pkg::Q_PTR_W'(at_sms_pkg::Q_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= at_sms_pkg::Q_CNT_W'(at_sms_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> o_full)
        else $error("full queue drained without a pop");

    a_empty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !i_push) |=> o_empty)
        else $error("empty queue filled without a push");

endmodule

// ===== rtl/at_sms_back.sv =====
module at_sms_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [at_sms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [at_sms_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  at_sms_pkg::t_event                  i_event,
    input  logic                                i_q_empty,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_cmd_valid,
    output logic [2:0]                          o_cmd_code,
    output logic                                o_done_pulse,
    output logic                                o_error_pulse,
    output logic [3:0]                          o_seq_state
);

    logic [at_sms_pkg::TIMEOUT_W-1:0]   r_timeout;
    logic [at_sms_pkg::RETRY_W-1:0]     r_retry_limit;

    at_sms_pkg::t_seq_state             r_state, n_state;
    logic [at_sms_pkg::RETRY_W-1:0]     r_retry, n_retry;
    logic [at_sms_pkg::ELAPSED_W-1:0]   r_elapsed, n_elapsed;

    logic [at_sms_pkg::ELAPSED_W-1:0]   w_elapsed_inc;
    logic                               w_late;
    logic [at_sms_pkg::RETRY_W:0]       w_retry_next;
    logic                               w_exhausted;
    logic                               n_cmd_valid, n_done, n_error;
    logic [2:0]                         n_cmd_code;

    logic                               r_out_valid;
    logic                               r_cmd_valid, r_done, r_error;
    logic [2:0]                         r_cmd_code;
    logic [3:0]                         r_seq_state;

    assign o_pop = !i_q_empty && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= at_sms_pkg::TIMEOUT_RESET;
            r_retry_limit <= at_sms_pkg::RETRY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                at_sms_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_wdata[at_sms_pkg::TIMEOUT_W-1:0];
                at_sms_pkg::CFG_RETRY: r_retry_limit <= i_cfg_wdata[at_sms_pkg::RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_elapsed_inc = (r_elapsed < at_sms_pkg::ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign w_late = w_elapsed_inc > at_sms_pkg::ELAPSED_W'(r_timeout);
    assign w_retry_next = {1'b0, r_retry} + 1'b1;
    assign w_exhausted = w_retry_next >= {1'b0, r_retry_limit};

    always_comb begin
        n_state = r_state;
        n_retry = r_retry;
        n_elapsed = r_elapsed;
        n_cmd_valid = 1'b0;
        n_cmd_code = at_sms_pkg::CMD_AT;
        n_done = 1'b0;
        n_error = 1'b0;
        case (i_event.kind)
            at_sms_pkg::EV_TICK: begin
                n_elapsed = w_elapsed_inc;
                case (r_state)
                    at_sms_pkg::ST_IDLE: begin
                    end
                    at_sms_pkg::ST_INIT: begin
                        n_cmd_valid = 1'b1;
                        n_cmd_code = at_sms_pkg::CMD_AT;
                        n_state = at_sms_pkg::ST_HANDSHAKE;
                        n_elapsed = '0;
                    end
                    at_sms_pkg::ST_HANDSHAKE, at_sms_pkg::ST_ECHO_OFF, at_sms_pkg::ST_CSMS_SET,
                    at_sms_pkg::ST_TEXT_MODE, at_sms_pkg::ST_ENCODING_SET,
                    at_sms_pkg::ST_CONTENT_PROMPT, at_sms_pkg::ST_CONFIRMATION: begin
                        if (w_late) begin
                            if (w_exhausted) begin
                                n_state = at_sms_pkg::ST_ERROR;
                                n_retry = '0;
                                n_error = 1'b1;
                            end else begin
                                n_retry = w_retry_next[at_sms_pkg::RETRY_W-1:0];
                                n_elapsed = '0;
                                if (r_state == at_sms_pkg::ST_HANDSHAKE) begin
                                    n_state = at_sms_pkg::ST_INIT;
                                end else if (r_state == at_sms_pkg::ST_CONTENT_PROMPT ||
                                             r_state == at_sms_pkg::ST_CONFIRMATION) begin
                                    n_state = at_sms_pkg::ST_PHONE_NUMBER;
                                end else begin
                                    // config stages all fall back to echo off, no resend
                                    n_state = at_sms_pkg::ST_ECHO_OFF;
                                end
                            end
                            // abandoned prompt still gets a ctrl-z
                            if (r_state == at_sms_pkg::ST_CONTENT_PROMPT) begin
                                n_cmd_valid = 1'b1;
                                n_cmd_code = at_sms_pkg::CMD_CTRL_Z;
                            end
                        end
                    end
                    at_sms_pkg::ST_PHONE_NUMBER: begin
                        n_cmd_valid = 1'b1;
                        n_cmd_code = at_sms_pkg::CMD_CMGS;
                        n_state = at_sms_pkg::ST_CONTENT_PROMPT;
                        n_elapsed = '0;
                    end
                    at_sms_pkg::ST_SEND_CONTENT: begin
                        n_cmd_valid = 1'b1;
                        n_cmd_code = at_sms_pkg::CMD_CONTENT;
                        n_state = at_sms_pkg::ST_SEND_TERMINATOR;
                        n_elapsed = '0;
                    end
                    at_sms_pkg::ST_SEND_TERMINATOR: begin
                        n_cmd_valid = 1'b1;
                        n_cmd_code = at_sms_pkg::CMD_CTRL_Z;
                        n_state = at_sms_pkg::ST_CONFIRMATION;
                        n_elapsed = '0;
                    end
                    at_sms_pkg::ST_COMPLETE: begin
                        n_state = at_sms_pkg::ST_IDLE;
                    end
                    at_sms_pkg::ST_ERROR: begin
                        n_state = at_sms_pkg::ST_IDLE;
                        n_retry = '0;
                        n_elapsed = '0;
                    end
                    default: begin
                        n_state = at_sms_pkg::ST_IDLE;
                    end
                endcase
            end
            at_sms_pkg::EV_LINE: begin
                case (r_state)
                    at_sms_pkg::ST_HANDSHAKE, at_sms_pkg::ST_ECHO_OFF, at_sms_pkg::ST_CSMS_SET,
                    at_sms_pkg::ST_TEXT_MODE: begin
                        if (i_event.seen[at_sms_pkg::SEEN_OK]) begin
                            n_cmd_valid = 1'b1;
                            n_retry = '0;
                            n_elapsed = '0;
                            if (r_state == at_sms_pkg::ST_HANDSHAKE) begin
                                n_cmd_code = at_sms_pkg::CMD_ATE0;
                                n_state = at_sms_pkg::ST_ECHO_OFF;
                            end else if (r_state == at_sms_pkg::ST_ECHO_OFF) begin
                                n_cmd_code = at_sms_pkg::CMD_CSMS;
                                n_state = at_sms_pkg::ST_CSMS_SET;
                            end else if (r_state == at_sms_pkg::ST_CSMS_SET) begin
                                n_cmd_code = at_sms_pkg::CMD_CMGF;
                                n_state = at_sms_pkg::ST_TEXT_MODE;
                            end else begin
                                n_cmd_code = at_sms_pkg::CMD_CSMP;
                                n_state = at_sms_pkg::ST_ENCODING_SET;
                            end
                        end
                    end
                    at_sms_pkg::ST_ENCODING_SET: begin
                        if (i_event.seen[at_sms_pkg::SEEN_OK]) begin
                            n_state = at_sms_pkg::ST_PHONE_NUMBER;
                            n_retry = '0;
                            n_elapsed = '0;
                        end
                    end
                    at_sms_pkg::ST_CONTENT_PROMPT: begin
                        if (i_event.seen[at_sms_pkg::SEEN_PROMPT]) begin
                            n_state = at_sms_pkg::ST_SEND_CONTENT;
                        end
                    end
                    at_sms_pkg::ST_CONFIRMATION: begin
                        if (i_event.seen[at_sms_pkg::SEEN_CMGS]) begin
                            n_state = at_sms_pkg::ST_COMPLETE;
                            n_retry = '0;
                            n_elapsed = '0;
                            n_done = 1'b1;
                        end
                    end
                    default: begin
                        // line dropped outside waiting states
                    end
                endcase
            end
            at_sms_pkg::EV_TRIGGER: begin
                if (r_state == at_sms_pkg::ST_IDLE) begin
                    n_state = at_sms_pkg::ST_INIT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= at_sms_pkg::ST_IDLE;
            r_retry <= '0;
            r_elapsed <= '0;
        end else if (o_pop) begin
            r_state <= n_state;
            r_retry <= n_retry;
            r_elapsed <= n_elapsed;
        end
    end

    // result register, refilled in the cycle it is taken if the queue holds an event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd_valid <= n_cmd_valid;
            r_cmd_code <= n_cmd_code;
            r_done <= n_done;
            r_error <= n_error;
            r_seq_state <= n_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd_code = r_cmd_code;
    assign o_done_pulse = r_done;
    assign o_error_pulse = r_error;
    assign o_seq_state = r_seq_state;

    a_done_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> (r_seq_state == at_sms_pkg::ST_COMPLETE && !r_error))
        else $error("done beat without complete state");

    a_error_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_error) |-> (r_seq_state == at_sms_pkg::ST_ERROR))
        else $error("error beat without error state");

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_cmd_valid) |-> (r_cmd_code == at_sms_pkg::CMD_AT))
        else $error("command code set without command");

    a_state_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && $past(o_pop) && i_rst_n && $past(i_rst_n)) |-> (r_seq_state == r_state))
        else $error("reported state differs from sequencer state");

endmodule

// ===== rtl/at_sms_send_sequencer_unit.sv =====
// Text-message send sequencer for an AT-command modem. Each input beat is a tick, a
// received modem byte or a send trigger (op 3 does nothing); every beat yields exactly
// one result beat with the command to transmit, done and error pulses and the state
// after the beat. A front stage assembles received bytes into lines and matches OK, the
// "> " prompt and +CMGS: on the fly; a two-entry queue hands tick, line-end and trigger
// events to the back stage, which runs the sequencer, timeouts and retries per event.
// One beat is accepted every cycle while the queue is not full; each result goes through
// the queue entry and the result register. The user must write the timeout and retry
// limit registers through the cfg port only while the block is idle; the block does not enforce this.
module at_sms_send_sequencer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [at_sms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [at_sms_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_op,
    input  logic [7:0]                          i_rx_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_cmd_valid,
    output logic [2:0]                          o_cmd_code,
    output logic                                o_done_pulse,
    output logic                                o_error_pulse,
    output logic [3:0]                          o_seq_state
);

    at_sms_pkg::t_event w_push_event, w_pop_event;
    logic               w_push, w_pop, w_q_empty, w_q_full;

    at_sms_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_event    (w_push_event)
    );

    at_sms_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_event),
        .i_pop   (w_pop),
        .o_data  (w_pop_event),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    at_sms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_event       (w_pop_event),
        .i_q_empty     (w_q_empty),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cmd_valid   (o_cmd_valid),
        .o_cmd_code    (o_cmd_code),
        .o_done_pulse  (o_done_pulse),
        .o_error_pulse (o_error_pulse),
        .o_seq_state   (o_seq_state)
    );

endmodule
